@@ rtl/assert_macros.svh @@
// Assertion macros shared by the checker modules of this block.
// Depends on nothing; include it by its bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Clocked assertion that stays active during reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

@@ rtl/hadf_pkg.sv @@
// Package of the hex dump formatter: character codes, microcode types and the control store.
// Depends on nothing; used by the top level and by its checker.
package hadf_pkg;

    localparam int UPC_W = 4;
    typedef logic [UPC_W-1:0] upc_t;

    // Step addresses of the microprogram.
    localparam upc_t U_IDLE   = 4'd0;
    localparam upc_t U_HEX_HI = 4'd1;
    localparam upc_t U_HEX_LO = 4'd2;
    localparam upc_t U_SEP    = 4'd3;
    localparam upc_t U_PAD    = 4'd4;
    localparam upc_t U_GAP1   = 4'd5;
    localparam upc_t U_GAP2   = 4'd6;
    localparam upc_t U_ASCII  = 4'd7;
    localparam upc_t U_CR     = 4'd8;
    localparam upc_t U_LF     = 4'd9;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] SHOW_LOW   = 8'd32;
    localparam logic [7:0] SHOW_HIGH  = 8'd128;

    // Character source selected by a control word.
    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_HEX_HI,
        SRC_HEX_LO,
        SRC_SPACE,
        SRC_STORE,
        SRC_CR,
        SRC_LF
    } src_t;

    // Sequencing rule of a control word.
    typedef enum logic [2:0] {
        SEQ_FETCH,
        SEQ_NEXT,
        SEQ_CLOSE,
        SEQ_PAD,
        SEQ_ASCII,
        SEQ_JUMP
    } seq_t;

    typedef struct packed {
        src_t src;
        seq_t seq;
        upc_t target;
        logic last;
    } ucode_t;

    function automatic ucode_t ucode_word(input upc_t upc);
        ucode_t w;
        w.src    = SRC_NONE;
        w.seq    = SEQ_JUMP;
        w.target = U_IDLE;
        w.last   = 1'b0;
        unique case (upc)
            U_IDLE: begin
                w.seq = SEQ_FETCH;
            end
            U_HEX_HI: begin
                w.src = SRC_HEX_HI;
                w.seq = SEQ_NEXT;
            end
            U_HEX_LO: begin
                w.src = SRC_HEX_LO;
                w.seq = SEQ_NEXT;
            end
            U_SEP: begin
                w.src = SRC_SPACE;
                w.seq = SEQ_CLOSE;
            end
            U_PAD: begin
                w.src = SRC_SPACE;
                w.seq = SEQ_PAD;
            end
            U_GAP1, U_GAP2: begin
                w.src = SRC_SPACE;
                w.seq = SEQ_NEXT;
            end
            U_ASCII: begin
                w.src = SRC_STORE;
                w.seq = SEQ_ASCII;
            end
            U_CR: begin
                w.src = SRC_CR;
                w.seq = SEQ_NEXT;
            end
            U_LF: begin
                w.src  = SRC_LF;
                w.seq  = SEQ_JUMP;
                w.last = 1'b1;
            end
            default: begin
                w.seq = SEQ_JUMP;
            end
        endcase
        return w;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h37 + {4'd0, nib});
    endfunction

    // Printable range of the ASCII column, both ends included.
    function automatic logic [7:0] shown_char(input logic [7:0] b);
        return (b >= SHOW_LOW && b <= SHOW_HIGH) ? b : CHAR_DOT;
    endfunction

endpackage

@@ rtl/hex_ascii_dump_formatter_unit.sv @@
// Top level of the hex dump formatter: microcode sequencer, line store and output register.
// Depends on hadf_pkg.
//
// The block turns a stream of bytes into hexdump text, one character per result item.
// Every byte gives two upper-case hex digits and a space at once, and is kept in a small
// line store. When BYTES_PER_LINE bytes are held, or on a byte flagged end_of_dump, the
// line is closed: three spaces for each missing byte of a short line, two spaces, the
// ASCII column (bytes 32 to 128 shown as they are, all others as '.') and CR LF. An item
// without a byte closes the current line the same way, or gives a blank padded line when
// no bytes are held. The last character caused by an item carries m_last_char. Control
// is a ten-step microprogram in a constant table; one control word per step picks the
// character source and the sequencing rule. The output register gives at most one
// character per cycle, held while m_ready is low. The padding and ASCII loops each
// leave their step without emitting once nothing is left, and the closing item with
// the most characters is a one-byte final line. A new item is taken only while the
// sequencer rests at its idle step, which it reaches as soon as the last character of
// the item is in the output register, even if that character has not been taken yet.
module hex_ascii_dump_formatter_unit
    import hadf_pkg::*;
#(
    parameter int BYTES_PER_LINE = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_has_byte,
    input  logic       s_end_of_dump,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_last_char
);

    localparam int CNT_W = $clog2(BYTES_PER_LINE + 1);
    localparam int IDX_W = $clog2(BYTES_PER_LINE);
    localparam int PAD_W = $clog2(3 * BYTES_PER_LINE + 1);
    localparam logic [CNT_W-1:0] LINE_FULL = CNT_W'(BYTES_PER_LINE);

    // Sequencer and line state.
    upc_t             upc_reg,     upc_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [PAD_W-1:0] pad_rem_reg, pad_rem_next;
    logic [CNT_W-1:0] asc_idx_reg, asc_idx_next;
    logic [7:0]       byte_reg;
    logic             close_reg;

    // Output register.
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_out_char_reg;
    logic             m_last_char_reg;

    logic [7:0]       line_store [BYTES_PER_LINE];

    ucode_t           uw;
    logic             slot_free;
    logic             in_acc;
    logic [CNT_W-1:0] base_cnt;
    logic [CNT_W-1:0] inc_cnt;
    logic [CNT_W-1:0] acc_count;
    logic [CNT_W-1:0] pad_bytes;
    logic [PAD_W-1:0] pad_x1;
    logic [PAD_W-1:0] pad_init;
    logic [7:0]       store_rd;
    logic             emit;
    logic             emit_last;
    logic [7:0]       emit_char;

    assign uw        = ucode_word(upc_reg);
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (uw.seq == SEQ_FETCH);
    assign in_acc    = s_valid && s_ready;

    // A full line is always closed, so the wrap to zero only guards the store index.
    assign base_cnt  = (count_reg >= LINE_FULL) ? '0 : count_reg;
    assign inc_cnt   = base_cnt + CNT_W'(1);
    assign acc_count = s_has_byte ? inc_cnt : count_reg;

    // Padding is three spaces for every byte missing from the line.
    assign pad_bytes = LINE_FULL - acc_count;
    assign pad_x1    = PAD_W'(pad_bytes);
    assign pad_init  = pad_x1 + (pad_x1 << 1);

    assign store_rd  = line_store[asc_idx_reg[IDX_W-1:0]];

    always_comb begin
        case (uw.src)
            SRC_HEX_HI: emit_char = hex_char(byte_reg[7:4]);
            SRC_HEX_LO: emit_char = hex_char(byte_reg[3:0]);
            SRC_STORE:  emit_char = shown_char(store_rd);
            SRC_CR:     emit_char = CHAR_CR;
            SRC_LF:     emit_char = CHAR_LF;
            default:    emit_char = CHAR_SPACE;
        endcase
    end

    // Sequencer: executes the control word of the current step.
    always_comb begin
        upc_next     = upc_reg;
        count_next   = count_reg;
        pad_rem_next = pad_rem_reg;
        asc_idx_next = asc_idx_reg;
        emit         = 1'b0;
        emit_last    = uw.last;
        unique case (uw.seq)
            SEQ_FETCH: begin
                if (in_acc) begin
                    upc_next     = s_has_byte ? U_HEX_HI : U_PAD;
                    count_next   = acc_count;
                    pad_rem_next = pad_init;
                    asc_idx_next = '0;
                end
            end
            SEQ_NEXT: begin
                emit = 1'b1;
                if (slot_free) begin
                    upc_next = upc_reg + UPC_W'(1);
                end
            end
            SEQ_CLOSE: begin
                // The separator ends the item unless this byte closes the line.
                emit      = 1'b1;
                emit_last = !close_reg;
                if (slot_free) begin
                    upc_next = close_reg ? (upc_reg + UPC_W'(1)) : uw.target;
                end
            end
            SEQ_PAD: begin
                if (pad_rem_reg == '0) begin
                    upc_next = upc_reg + UPC_W'(1);
                end else begin
                    emit = 1'b1;
                    if (slot_free) begin
                        pad_rem_next = pad_rem_reg - PAD_W'(1);
                    end
                end
            end
            SEQ_ASCII: begin
                if (asc_idx_reg == count_reg) begin
                    upc_next = upc_reg + UPC_W'(1);
                end else begin
                    emit = 1'b1;
                    if (slot_free) begin
                        asc_idx_next = asc_idx_reg + CNT_W'(1);
                    end
                end
            end
            SEQ_JUMP: begin
                // Only the line feed step and the unused step addresses jump; the line is then empty again.
                emit = (uw.src != SRC_NONE);
                if (slot_free || !emit) begin
                    upc_next   = uw.target;
                    count_next = '0;
                end
            end
            default: begin
                upc_next = U_IDLE;
            end
        endcase
    end

    always_comb begin
        if (emit && slot_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg     <= U_IDLE;
            count_reg   <= '0;
            pad_rem_reg <= '0;
            asc_idx_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            upc_reg     <= upc_next;
            count_reg   <= count_next;
            pad_rem_reg <= pad_rem_next;
            asc_idx_reg <= asc_idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            byte_reg  <= s_data_byte;
            close_reg <= s_has_byte ? ((inc_cnt >= LINE_FULL) || s_end_of_dump) : 1'b1;
            if (s_has_byte) begin
                line_store[base_cnt[IDX_W-1:0]] <= s_data_byte;
            end
        end
        if (emit && slot_free) begin
            m_out_char_reg  <= emit_char;
            m_last_char_reg <= emit_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_char  = m_out_char_reg;
    assign m_last_char = m_last_char_reg;

endmodule

@@ rtl/hadf_checker.sv @@
// Port-level checker of the hex dump formatter, bound to the top level below.
// Depends on hadf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hadf_checker
    import hadf_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_out_char,
    input logic       m_last_char
);

    // The output is empty right after reset.
    `ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_valid)

    // A stalled character holds.
    `ASSERT_CLK(a_out_hold, aclk, aresetn,
        m_valid && !m_ready |=> m_valid && $stable(m_out_char) && $stable(m_last_char))

    // An item ends either on the separator after its hex digits or on the line feed.
    `ASSERT_CLK(a_last_kind, aclk, aresetn,
        m_valid && m_last_char |-> (m_out_char == CHAR_LF || m_out_char == CHAR_SPACE))

    // A carriage return is followed at once by the closing line feed.
    `ASSERT_CLK(a_cr_lf, aclk, aresetn,
        m_valid && m_ready && m_out_char == CHAR_CR |=> m_valid && m_out_char == CHAR_LF && m_last_char)

    // The block works on one item at a time.
    `ASSERT_CLK(a_one_item, aclk, aresetn, s_valid && s_ready |=> !s_ready)

endmodule

bind hex_ascii_dump_formatter_unit hadf_checker u_hadf_checker (.*);
